[design/sfir_pkg.sv]
// ----------------------------------------------------------------------------
// sfir_pkg: shared types and constants of the symmetric three-axis fir
// widths, register indexes, reset values and the pipeline enable bundle
// ----------------------------------------------------------------------------
package sfir_pkg;

    localparam int SAMPLE_W    = 20;               // q10 sample
    localparam int COEF_W      = 16;               // q1.15 coefficient
    localparam int AXES        = 3;
    localparam int VEC_W       = AXES * SAMPLE_W;  // one vector, x lowest
    localparam int TDATA_W     = ((VEC_W + 7) / 8) * 8;
    localparam int HALF_WINDOW_DEF = 3;
    localparam int HALF_MAX    = 3;

    localparam int PAIR_W      = SAMPLE_W + 1;
    localparam int PROD_W      = PAIR_W + COEF_W;
    localparam int ACC_W       = PROD_W + 3;
    localparam int FRAC_BITS   = 15;

    localparam int CFG_IDX_W   = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_OUTER  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_THIRD  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_CENTRE = 2'd3;

    localparam logic signed [COEF_W-1:0] CENTRE_RESET = 16'sh7FFF;

    // one enable per arithmetic stage
    typedef struct packed {
        logic a;   // pair sums
        logic b;   // products
        logic c;   // sum, round, saturate into the output register
    } t_stage_en;

endpackage

[design/sfir_cell.sv]
// ----------------------------------------------------------------------------
// sfir_cell: one tap of the sample window
// holds one three-axis vector and hands it to the next tap on each shift
// ----------------------------------------------------------------------------
module sfir_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_shift,
    input  logic [sfir_pkg::VEC_W-1:0] i_d,
    output logic [sfir_pkg::VEC_W-1:0] o_q
);
    import sfir_pkg::*;

    logic [VEC_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else if (i_shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

[design/sfir_axis.sv]
// ----------------------------------------------------------------------------
// sfir_axis: folded fir arithmetic for one axis
// pair sums, products, then sum with rounding and saturation
// ----------------------------------------------------------------------------
module sfir_axis #(
    parameter int HALF_WINDOW = sfir_pkg::HALF_WINDOW_DEF
) (
    input  logic                                i_clk,
    input  sfir_pkg::t_stage_en                 i_en,
    input  logic signed [sfir_pkg::SAMPLE_W-1:0] i_taps [2*HALF_WINDOW+1],
    input  logic signed [sfir_pkg::COEF_W-1:0]  i_coef [HALF_WINDOW],
    input  logic signed [sfir_pkg::COEF_W-1:0]  i_centre,
    input  logic                                i_first,   // item in stage b is the first one
    output logic signed [sfir_pkg::SAMPLE_W-1:0] o_res
);
    import sfir_pkg::*;

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] OUT_MAX =
        ACC_W'((longint'(1) << (SAMPLE_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] OUT_MIN = -(ACC_W'(1) <<< (SAMPLE_W - 1));

    logic signed [PAIR_W-1:0]   r_pair [HALF_WINDOW];
    logic signed [SAMPLE_W-1:0] r_mid;
    logic signed [SAMPLE_W-1:0] r_newest_a;
    logic signed [PROD_W-1:0]   r_prod [HALF_WINDOW];
    logic signed [PROD_W-1:0]   r_mprod;
    logic signed [SAMPLE_W-1:0] r_newest_b;
    logic signed [SAMPLE_W-1:0] r_res;

    logic signed [ACC_W-1:0]    n_acc;
    logic signed [ACC_W-1:0]    n_scaled;
    logic signed [SAMPLE_W-1:0] n_res;

    // stage a: fold newest-k with oldest+k
    always_ff @(posedge i_clk) begin
        if (i_en.a) begin
            for (int k = 0; k < HALF_WINDOW; k++) begin
                r_pair[k] <= PAIR_W'(i_taps[k]) + PAIR_W'(i_taps[2*HALF_WINDOW-k]);
            end
            r_mid      <= i_taps[HALF_WINDOW];
            r_newest_a <= i_taps[0];
        end
    end

    // stage b: one multiplier per pair plus the centre tap
    always_ff @(posedge i_clk) begin
        if (i_en.b) begin
            for (int k = 0; k < HALF_WINDOW; k++) begin
                r_prod[k] <= PROD_W'(r_pair[k] * i_coef[k]);
            end
            r_mprod    <= PROD_W'(r_mid * i_centre);
            r_newest_b <= r_newest_a;
        end
    end

    // stage c: sum, round half up, floor shift, clamp
    always_comb begin
        n_acc = ACC_W'(r_mprod) + ROUND_HALF;
        for (int k = 0; k < HALF_WINDOW; k++) begin
            n_acc = n_acc + ACC_W'(r_prod[k]);
        end
        n_scaled = n_acc >>> FRAC_BITS;
        if (n_scaled > OUT_MAX) begin
            n_res = OUT_MAX[SAMPLE_W-1:0];
        end else if (n_scaled < OUT_MIN) begin
            n_res = OUT_MIN[SAMPLE_W-1:0];
        end else begin
            n_res = n_scaled[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.c) begin
            r_res <= i_first ? r_newest_b : n_res;
        end
    end

    assign o_res = r_res;

endmodule

[design/symmetric_fir_three_axis_top.sv]
// ----------------------------------------------------------------------------
// symmetric_fir_three_axis_top: three-axis linear-phase low-pass fir
// folded symmetric taps over a shifting window of 2*HALF_WINDOW+1 vectors
// ----------------------------------------------------------------------------
// pipeline: an input transaction is registered in window cell 0 on the accepting edge,
//   then in the pair sums, the products and the sum/round/saturate output register
// throughput: one transaction per cycle; each stage has its own valid bit
//   and stalls only when the stage after it is full and not draining
// reset: synchronous active low; window cleared to zero, centre tap 32767,
//   other taps 0; the first sample after reset is passed through unchanged
// ----------------------------------------------------------------------------
module symmetric_fir_three_axis_top #(
    parameter int HALF_WINDOW = sfir_pkg::HALF_WINDOW_DEF   // 1 to 3
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [sfir_pkg::TDATA_W-1:0]    s_axis_tdata,   // sample_x, sample_y, sample_z
    // output stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [sfir_pkg::TDATA_W-1:0]    m_axis_tdata,   // filt_x, filt_y, filt_z
    // coefficient write port
    input  logic                            i_cfg_we,
    input  logic [sfir_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sfir_pkg::COEF_W-1:0]     i_cfg_wdata
);
    import sfir_pkg::*;

    localparam int WIN_LEN = 2 * HALF_WINDOW + 1;

    // coefficient registers
    logic signed [COEF_W-1:0] r_tap_outer;
    logic signed [COEF_W-1:0] r_tap_second;
    logic signed [COEF_W-1:0] r_tap_third;
    logic signed [COEF_W-1:0] r_tap_centre;

    // pipeline control: window, stage a, stage b, output
    logic r_v0, r_va, r_vb, r_vc;
    logic r_f0, r_fa, r_fb;         // first-sample flag riding with the transaction
    logic r_primed;

    logic      w_rdy0, w_rdya, w_rdyb, w_rdyc;
    logic      w_accept;
    t_stage_en w_en;

    logic [VEC_W-1:0] w_cell_q [WIN_LEN];
    logic signed [SAMPLE_W-1:0] w_taps [AXES][WIN_LEN];
    logic signed [COEF_W-1:0]   w_coef [HALF_WINDOW];
    logic signed [SAMPLE_W-1:0] w_res  [AXES];

    // ------------------------------------------------------------------
    // configuration writes
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_outer  <= '0;
            r_tap_second <= '0;
            r_tap_third  <= '0;
            r_tap_centre <= CENTRE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TAP_OUTER:  r_tap_outer  <= i_cfg_wdata;
                CFG_TAP_SECOND: r_tap_second <= i_cfg_wdata;
                CFG_TAP_THIRD:  r_tap_third  <= i_cfg_wdata;
                CFG_TAP_CENTRE: r_tap_centre <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // pair k uses the k-th coefficient from the outside in
    for (genvar k = 0; k < HALF_WINDOW; k++) begin : g_coef
        if (k == 0) begin : g_outer
            assign w_coef[k] = r_tap_outer;
        end else if (k == 1) begin : g_second
            assign w_coef[k] = r_tap_second;
        end else begin : g_third
            assign w_coef[k] = r_tap_third;
        end
    end

    // ------------------------------------------------------------------
    // handshake and stage enables, ready ripples back from the output
    // ------------------------------------------------------------------
    assign w_rdyc   = !r_vc || m_axis_tready;
    assign w_en.c   = r_vb && w_rdyc;
    assign w_rdyb   = !r_vb || w_rdyc;
    assign w_en.b   = r_va && w_rdyb;
    assign w_rdya   = !r_va || w_rdyb;
    assign w_en.a   = r_v0 && w_rdya;
    assign w_rdy0   = !r_v0 || w_rdya;

    assign s_axis_tready = w_rdy0;
    assign w_accept      = s_axis_tvalid && w_rdy0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0     <= 1'b0;
            r_va     <= 1'b0;
            r_vb     <= 1'b0;
            r_vc     <= 1'b0;
            r_f0     <= 1'b0;
            r_fa     <= 1'b0;
            r_fb     <= 1'b0;
            r_primed <= 1'b0;
        end else begin
            r_v0 <= w_accept || (r_v0 && !w_en.a);
            r_va <= w_en.a   || (r_va && !w_en.b);
            r_vb <= w_en.b   || (r_vb && !w_en.c);
            r_vc <= w_en.c   || (r_vc && !m_axis_tready);
            if (w_accept) begin
                r_f0     <= !r_primed;
                r_primed <= 1'b1;
            end
            if (w_en.a) begin
                r_fa <= r_f0;
            end
            if (w_en.b) begin
                r_fb <= r_fa;
            end
        end
    end

    // ------------------------------------------------------------------
    // window: a row of cells, newest vector in cell 0, shifts per transaction
    // ------------------------------------------------------------------
    for (genvar i = 0; i < WIN_LEN; i++) begin : g_win
        if (i == 0) begin : g_head
            sfir_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_accept),
                .i_d     (s_axis_tdata[VEC_W-1:0]),
                .o_q     (w_cell_q[i])
            );
        end else begin : g_body
            sfir_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_accept),
                .i_d     (w_cell_q[i-1]),
                .o_q     (w_cell_q[i])
            );
        end
        for (genvar a = 0; a < AXES; a++) begin : g_split
            assign w_taps[a][i] = w_cell_q[i][a*SAMPLE_W +: SAMPLE_W];
        end
    end

    // ------------------------------------------------------------------
    // one arithmetic pipeline per axis, shared coefficients
    // ------------------------------------------------------------------
    for (genvar a = 0; a < AXES; a++) begin : g_axis
        sfir_axis #(
            .HALF_WINDOW (HALF_WINDOW)
        ) u_axis (
            .i_clk    (i_clk),
            .i_en     (w_en),
            .i_taps   (w_taps[a]),
            .i_coef   (w_coef),
            .i_centre (r_tap_centre),
            .i_first  (r_fb),
            .o_res    (w_res[a])
        );
    end

    assign m_axis_tvalid = r_vc;
    assign m_axis_tdata  = {(TDATA_W - VEC_W)'(0), w_res[2], w_res[1], w_res[0]};

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // an accepted transaction always lands in the window stage
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_v0)
        else $error("accepted transaction did not reach the window stage");

    // once primed, the block stays primed until reset
    a_primed_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_primed |=> r_primed)
        else $error("primed flag dropped without reset");

    // a first-sample flag can only exist after priming
    a_first_primed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v0 && r_f0) |-> r_primed)
        else $error("first-sample flag without primed state");

    // stage b moves into the output register whenever it is enabled
    a_out_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_en.c |=> r_vc)
        else $error("output register not filled after stage c enable");

    // stage b never advances out of an empty stage a
    a_no_ghost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_en.b |-> r_va)
        else $error("stage b enabled from an empty stage a");

endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for the three-axis symmetric fir
// streams q10 accelerometer vectors through the block under several tap
// settings and compares every filtered vector, axis by axis, against a
// cycle-free folded-fir predictor kept in a small scoreboard class
// ----------------------------------------------------------------------------
import sfir_pkg::*;

class accel_fir_scoreboard;
    localparam int     HALF    = HALF_WINDOW_DEF;
    localparam int     WIN_LEN = 2 * HALF + 1;
    localparam longint OUT_MAX = 524287;
    localparam longint OUT_MIN = -524288;

    // predictor copy of the coefficients and the sample window
    logic signed [COEF_W-1:0] pair_tap [HALF_MAX];
    logic signed [COEF_W-1:0] centre_tap;
    logic [VEC_W-1:0]         window [WIN_LEN];
    int                       head;
    bit                       primed;

    // filtered vectors still owed by the block, oldest first
    logic [VEC_W-1:0]         filtered_due [$];

    int errors;
    int compared;
    int clipped;

    function new();
        foreach (pair_tap[k]) pair_tap[k] = '0;
        centre_tap = CENTRE_RESET;
        foreach (window[i]) window[i] = '0;
        head     = 0;
        primed   = 1'b0;
        errors   = 0;
        compared = 0;
        clipped  = 0;
    endfunction

    function void write_tap(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] val);
        case (idx)
            CFG_TAP_OUTER:  pair_tap[0] = val;
            CFG_TAP_SECOND: pair_tap[1] = val;
            CFG_TAP_THIRD:  pair_tap[2] = val;
            CFG_TAP_CENTRE: centre_tap  = val;
            default: ;
        endcase
    endfunction

    function longint axis_of(logic [VEC_W-1:0] w, int a);
        logic signed [SAMPLE_W-1:0] s;
        s = w[a*SAMPLE_W +: SAMPLE_W];
        return longint'(s);
    endfunction

    // folded fir: newest-k paired with oldest+k, centre tap on the middle sample
    function logic [VEC_W-1:0] smooth_vector(logic [VEC_W-1:0] v);
        logic [VEC_W-1:0] res;
        longint           acc;
        longint           pair;
        longint           r;
        int               newer;
        int               older;
        // first vector after reset goes straight through
        if (!primed) begin
            primed    = 1'b1;
            head      = 0;
            window[0] = v;
            return v;
        end
        head         = (head + 1) % WIN_LEN;
        window[head] = v;
        for (int a = 0; a < AXES; a++) begin
            acc = 0;
            for (int k = 0; k < HALF && k < HALF_MAX; k++) begin
                newer = (head + WIN_LEN - k) % WIN_LEN;
                older = (head + WIN_LEN - (2 * HALF - k)) % WIN_LEN;
                pair  = axis_of(window[newer], a) + axis_of(window[older], a);
                acc  += pair * longint'(pair_tap[k]);
            end
            acc += axis_of(window[(head + WIN_LEN - HALF) % WIN_LEN], a) * longint'(centre_tap);
            // round half up, then clip to the q10 range
            r = (acc + 64'sd16384) >>> FRAC_BITS;
            if (r > OUT_MAX) begin
                r = OUT_MAX;
                clipped++;
            end else if (r < OUT_MIN) begin
                r = OUT_MIN;
                clipped++;
            end
            res[a*SAMPLE_W +: SAMPLE_W] = r[SAMPLE_W-1:0];
        end
        return res;
    endfunction

    function void take_sample(logic [VEC_W-1:0] v);
        filtered_due.push_back(smooth_vector(v));
    endfunction

    function void check_filtered(logic [VEC_W-1:0] got);
        logic [VEC_W-1:0] want;
        if (filtered_due.size() == 0) begin
            $display("%0t: filtered vector with none outstanding: expected none, actual %h",
                     $time, got);
            errors++;
            return;
        end
        want = filtered_due.pop_front();
        compared++;
        for (int a = 0; a < AXES; a++) begin
            if (got[a*SAMPLE_W +: SAMPLE_W] !== want[a*SAMPLE_W +: SAMPLE_W]) begin
                $display("%0t: axis %0d expected %0d actual %0d", $time, a,
                         axis_of(want, a), axis_of(got, a));
                errors++;
            end
        end
    endfunction

    function int pending();
        return filtered_due.size();
    endfunction
endclass

module tb;

    localparam int LATENCY         = 4;
    localparam int SETTLE_CYCLES   = LATENCY + 4;
    localparam int QUIET_LIMIT     = 2000;   // cycles without any transaction
    localparam int PHASES          = 7;
    localparam int ITEMS_PER_PHASE = 186;

    localparam logic [SAMPLE_W-1:0] S_MAX  = 20'h7FFFF;
    localparam logic [SAMPLE_W-1:0] S_MIN  = 20'h80000;
    localparam logic [SAMPLE_W-1:0] S_ONE  = 20'h00001;
    localparam logic [SAMPLE_W-1:0] S_NEG1 = 20'hFFFFF;
    localparam logic [SAMPLE_W-1:0] S_ZERO = 20'h00000;

    // clock and synchronous active-low reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // input stream, driven by the sender tasks
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [TDATA_W-1:0] s_axis_tdata  = '0;   // sample_x, sample_y, sample_z, zero pad

    // output stream, tready driven by the stall pattern below
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [TDATA_W-1:0] m_axis_tdata;          // filt_x, filt_y, filt_z, zero pad

    // coefficient write port
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_TAP_OUTER;
    logic [COEF_W-1:0]    i_cfg_wdata = '0;

    accel_fir_scoreboard sb;

    // tap settings for the random phases: outer, second, third, centre
    logic [COEF_W-1:0] tap_plan [PHASES][4];

    // receiver stall style, changed per phase
    int rdy_mode    = 1;
    int stall_left  = 0;
    int rdy_cycle   = 0;
    int quiet_count = 0;
    int settings    = 0;

    symmetric_fir_three_axis_top #(
        .HALF_WINDOW   (HALF_WINDOW_DEF)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // receiver back-pressure: always ready, random, periodic, or rare long stalls
    always @(posedge i_clk) begin
        rdy_cycle++;
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            case (rdy_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 9) < 7);
                2: m_axis_tready <= ((rdy_cycle % 7) < 3);
                default: begin
                    if ($urandom_range(0, 15) == 0) begin
                        stall_left = $urandom_range(1, 12);
                        m_axis_tready <= 1'b0;
                    end else begin
                        m_axis_tready <= 1'b1;
                    end
                end
            endcase
        end
    end

    // output monitor: pre-edge values, one check per output transaction
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready)
            sb.check_filtered(m_axis_tdata[VEC_W-1:0]);
    end

    // watchdog: too long without any transaction on either stream or the write port
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready === 1'b1) ||
            (m_axis_tvalid === 1'b1 && m_axis_tready) || i_cfg_we)
            quiet_count = 0;
        else
            quiet_count++;
        if (quiet_count >= QUIET_LIMIT) begin
            $display("%0t: no transaction for %0d cycles, %0d vectors still owed",
                     $time, quiet_count, sb.pending());
            $display("symmetric_fir_three_axis_top: mismatch");
            $finish;
        end
    end

    function automatic logic [VEC_W-1:0] make_vec(logic [SAMPLE_W-1:0] x,
                                                  logic [SAMPLE_W-1:0] y,
                                                  logic [SAMPLE_W-1:0] z);
        return {z, y, x};
    endfunction

    // one random axis: full range, small, mid-range or a corner value
    function automatic logic [SAMPLE_W-1:0] rand_axis();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 8)
            return SAMPLE_W'($urandom());
        if (pick < 14)
            return SAMPLE_W'(int'($urandom_range(0, 4095)) - 2048);
        if (pick < 17)
            return SAMPLE_W'(int'($urandom_range(0, 262143)) - 131072);
        case ($urandom_range(0, 4))
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return S_ZERO;
            3:       return S_NEG1;
            default: return S_ONE;
        endcase
    endfunction

    // present one vector and hold it until the block takes it;
    // tvalid stays high so a following vector can go out back to back
    task automatic push_vec(input logic [VEC_W-1:0] v);
        s_axis_tdata  <= {{(TDATA_W - VEC_W){1'b0}}, v};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        sb.take_sample(v);
    endtask

    // stop sending and wait until every owed vector has come out
    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // write all four coefficients, one per cycle; only called while idle
    task automatic program_taps(input logic [COEF_W-1:0] t_outer,
                                input logic [COEF_W-1:0] t_second,
                                input logic [COEF_W-1:0] t_third,
                                input logic [COEF_W-1:0] t_centre);
        logic [CFG_IDX_W-1:0] idx [4];
        logic [COEF_W-1:0]    val [4];
        idx = '{CFG_TAP_OUTER, CFG_TAP_SECOND, CFG_TAP_THIRD, CFG_TAP_CENTRE};
        val = '{t_outer, t_second, t_third, t_centre};
        for (int i = 0; i < 4; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx[i];
            i_cfg_wdata <= val[i];
            sb.write_tap(idx[i], val[i]);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        settings++;
    endtask

    initial begin
        logic [VEC_W-1:0] v;
        logic [VEC_W-1:0] last_vec;
        int               sent;
        int               burst;
        int               gap;
        int               gap_max;

        sb       = new();
        last_vec = '0;

        // typical low-pass, all zero, both full-scale extremes, random, mixed signs
        tap_plan[0] = '{16'd1200, 16'd4100, 16'd7800, 16'd10600};
        tap_plan[1] = '{16'h0000, 16'h0000, 16'h0000, 16'h0000};
        tap_plan[2] = '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF};
        tap_plan[3] = '{16'h8000, 16'h8000, 16'h8000, 16'h8000};
        tap_plan[4] = '{COEF_W'($urandom()), COEF_W'($urandom()),
                        COEF_W'($urandom()), COEF_W'($urandom())};
        tap_plan[5] = '{16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001};
        tap_plan[6] = '{COEF_W'($urandom()), COEF_W'($urandom()),
                        COEF_W'($urandom()), COEF_W'($urandom())};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset taps: first vector passes through, the next two see an empty
        // middle slot, the fourth is the first one scaled by the reset centre tap
        settings++;
        push_vec(make_vec(S_MAX, S_MIN, S_NEG1));
        push_vec(make_vec(S_ZERO, S_ONE, S_MIN));
        push_vec(make_vec(S_NEG1, S_MAX, 20'h55555));
        push_vec(make_vec(S_ONE, 20'hFFFFE, 20'hAAAAA));
        hold_until_drained();

        // full-scale taps of both signs while the window is still partly empty,
        // then runs of corner values to drive both clip limits
        program_taps(16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF);
        push_vec(make_vec(S_MAX, S_MAX, S_MAX));
        push_vec(make_vec(S_MIN, S_MIN, S_MIN));
        push_vec(make_vec(S_MAX, S_MIN, S_ZERO));
        push_vec(make_vec(S_ZERO, S_ZERO, S_ZERO));
        push_vec(make_vec(S_MAX, S_MAX, S_MIN));
        push_vec(make_vec(S_MAX, S_MAX, S_MIN));
        push_vec(make_vec(S_MIN, S_MIN, S_MAX));
        push_vec(make_vec(S_MIN, S_MIN, S_MAX));
        hold_until_drained();

        // most negative taps on every pair and the centre
        program_taps(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        push_vec(make_vec(S_MIN, S_MIN, S_MIN));
        push_vec(make_vec(S_MIN, S_MIN, S_MIN));
        push_vec(make_vec(S_MAX, S_MAX, S_MAX));
        push_vec(make_vec(S_MAX, S_MAX, S_MAX));
        push_vec(make_vec(S_NEG1, S_ONE, S_ZERO));
        push_vec(make_vec(S_MIN, S_MAX, S_NEG1));
        hold_until_drained();

        // random phases, each under its own taps and stall style
        for (int p = 0; p < PHASES; p++) begin
            program_taps(tap_plan[p][0], tap_plan[p][1], tap_plan[p][2], tap_plan[p][3]);
            rdy_mode <= p % 4;
            // some phases stream with no sender gaps at all
            gap_max = (p % 3 == 1) ? 0 : 8;
            sent    = 0;
            while (sent < ITEMS_PER_PHASE) begin
                burst = $urandom_range(1, 24);
                for (int j = 0; j < burst && sent < ITEMS_PER_PHASE; j++) begin
                    if ($urandom_range(0, 3) == 0) begin
                        // slowly moving signal: previous vector plus a little jitter
                        for (int a = 0; a < AXES; a++)
                            v[a*SAMPLE_W +: SAMPLE_W] = last_vec[a*SAMPLE_W +: SAMPLE_W]
                                + SAMPLE_W'($urandom_range(0, 63)) - SAMPLE_W'(32);
                    end else begin
                        v = make_vec(rand_axis(), rand_axis(), rand_axis());
                    end
                    push_vec(v);
                    last_vec = v;
                    sent++;
                    // mid-phase pause until the pipeline is empty
                    if (sent == ITEMS_PER_PHASE / 2 && p % 2 == 0)
                        hold_until_drained();
                end
                if (gap_max > 0) begin
                    gap = $urandom_range(0, gap_max);
                    if (gap > 0) begin
                        s_axis_tvalid <= 1'b0;
                        repeat (gap) @(posedge i_clk);
                    end
                end
            end
            hold_until_drained();
        end

        $display("run covered %0d vectors over %0d tap settings, %0d axis outputs clipped",
                 sb.compared, settings, sb.clipped);
        $display("stall styles: none, random, periodic and long; %0d axis mismatches",
                 sb.errors);
        if (sb.errors == 0)
            $display("symmetric_fir_three_axis_top: match");
        else
            $display("symmetric_fir_three_axis_top: mismatch");
        $finish;
    end

endmodule

[sim.f]
design/sfir_pkg.sv
design/sfir_cell.sv
design/sfir_axis.sv
design/symmetric_fir_three_axis_top.sv
dv/tb.sv
